/* design/cebv_pkg.sv */
// Shared types and constants for the camera basis and view pipeline.
// No dependencies; imported by every other design file but cebv_if.
`timescale 1ns / 1ps
`default_nettype none

package cebv_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// Stages in the sine unit, from angle to registered Q30 result.
	localparam int SINE_LAT = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WU_X = 2'd0,
		CFG_WU_Y = 2'd1,
		CFG_WU_Z = 2'd2
	} cfg_reg_t;

	// Q30 vector, also used for the Q16.16 eye position.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

endpackage

`default_nettype wire

/* design/cebv_if.sv */
// Item channels of the camera basis block: pose in, basis and view out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cebv_pose_if;
	logic               valid;
	logic               ready;
	logic        [15:0] yaw_angle;
	logic        [15:0] pitch_angle;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;

	modport source (output valid, yaw_angle, pitch_angle, eye_x, eye_y, eye_z, input ready);
	modport sink   (input valid, yaw_angle, pitch_angle, eye_x, eye_y, eye_z, output ready);
endinterface

interface cebv_basis_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] front_x;
	logic signed [15:0] front_y;
	logic signed [15:0] front_z;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic signed [15:0] right_z;
	logic signed [15:0] up_x;
	logic signed [15:0] up_y;
	logic signed [15:0] up_z;
	logic signed [35:0] view_tx;
	logic signed [35:0] view_ty;
	logic signed [35:0] view_tz;

	modport source (output valid, front_x, front_y, front_z, right_x, right_y, right_z,
		up_x, up_y, up_z, view_tx, view_ty, view_tz, input ready);
	modport sink   (input valid, front_x, front_y, front_z, right_x, right_y, right_z,
		up_x, up_y, up_z, view_tx, view_ty, view_tz, output ready);
endinterface

`default_nettype wire

/* design/cebv_sine.sv */
// Pipelined quarter-wave polynomial sine, binary angle in, signed Q30 out.
// Depends on cebv_pkg (SINE_LAT stages, no valid: caller tracks it).
`timescale 1ns / 1ps
`default_nettype none

module cebv_sine import cebv_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [ANGLE_BITS-1:0] angle,
	output logic signed [31:0]         sine
);

	localparam int QB = ANGLE_BITS - 2;
	localparam logic [30:0] SIN_A = 31'd1686629713;
	localparam logic [29:0] SIN_B = 30'd688904866;
	localparam logic [26:0] SIN_C = 27'd76016977;

	logic [1:0]    quad;
	logic [QB-1:0] r;
	logic [QB:0]   r_eff;
	logic [61:0]   zz;
	logic [57:0]   cz;
	logic [60:0]   pz;
	logic [61:0]   qz;
	logic [30:0]   smag;

	logic [30:0] z_s1, z_s2, z_s3, z_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [30:0] z2_s2, z2_s3;
	logic [29:0] p_s3;
	logic [30:0] q_s4;
	logic signed [31:0] sine_s5;

	assign quad  = angle[ANGLE_BITS-1 -: 2];
	assign r     = angle[QB-1:0];
	// odd quadrants run the quarter wave backwards
	assign r_eff = quad[0] ? (((QB+1)'(1) << QB) - {1'b0, r}) : {1'b0, r};

	assign zz   = 62'(z_s1) * 62'(z_s1);
	assign cz   = 58'(SIN_C) * 58'(z2_s2);
	assign pz   = 61'(p_s3) * 61'(z2_s3);
	assign qz   = 62'(q_s4) * 62'(z_s4);
	assign smag = qz[60:30];

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= 31'(r_eff) << (32 - ANGLE_BITS);
			neg_s1  <= quad[1];
			z2_s2   <= zz[60:30];
			z_s2    <= z_s1;
			neg_s2  <= neg_s1;
			p_s3    <= SIN_B - 30'(cz >> 30);
			z2_s3   <= z2_s2;
			z_s3    <= z_s2;
			neg_s3  <= neg_s2;
			q_s4    <= SIN_A - 31'(pz >> 30);
			z_s4    <= z_s3;
			neg_s4  <= neg_s3;
			sine_s5 <= neg_s4 ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
		end
	end

	assign sine = sine_s5;

endmodule

`default_nettype wire

/* design/cebv_norm.sv */
// Pipelined vector normalize: scale to [2^30, 2^31), square root, three dividers.
// Depends on cebv_pkg (vec_t). Carries a valid bit and a side tag alongside.
`timescale 1ns / 1ps
`default_nettype none

module cebv_norm import cebv_pkg::*; #(
	parameter int IN_W  = 32,
	parameter int TAG_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_i,
	input  wire logic [2:0][IN_W-1:0] v_i,
	input  wire logic [TAG_W-1:0]     tag_i,
	output logic                      vld_o,
	output vec_t                      vec_o,
	output logic [TAG_W-1:0]          tag_o
);

	localparam int PW        = $clog2(IN_W);
	localparam int SQ_ITERS  = 32;
	localparam int DIV_STEPS = 31;
	localparam int NSQ       = SQ_ITERS / 2;
	localparam int NDIV      = (DIV_STEPS + 1) / 2;
	localparam int LAT       = 5 + NSQ + 1 + NDIV + 1;
	localparam int SW        = TAG_W + 4;

	typedef struct packed {
		logic [63:0]      n;
		logic [63:0]      r;
		logic [2:0][30:0] m;
	} sqrt_st_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0][30:0] lo;
	} div_st_t;

	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input int k);
		sqrt_st_t    o;
		logic [63:0] b;
		logic [63:0] t;
		o = s;
		b = 64'(1) << (62 - 2 * k);
		t = s.r + b;
		if (s.n >= t) begin
			o.n = s.n - t;
			o.r = (s.r >> 1) + b;
		end else begin
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	function automatic div_st_t div_step(input div_st_t s, input logic [31:0] len);
		div_st_t     o;
		logic [32:0] t;
		logic        qb;
		o = s;
		for (int l = 0; l < 3; l++) begin
			t  = {s.rem[l], s.lo[l][30]};
			qb = 1'b0;
			if (t >= {1'b0, len}) begin
				t  = t - {1'b0, len};
				qb = 1'b1;
			end
			o.rem[l] = t[31:0];
			o.lo[l]  = {s.lo[l][29:0], qb};
		end
		return o;
	endfunction

	logic [LAT-1:0]         vld_s;
	logic [LAT-1:0][SW-1:0] side_s;
	logic [SW-1:0]          side_in;

	logic [2:0][IN_W-1:0] mag_c;
	logic [IN_W-1:0]      mx_c;
	logic [PW-1:0]        pos_c;

	logic [2:0][IN_W-1:0] mag_s1, mag_s2;
	logic [IN_W-1:0]      mx_s1;
	logic [PW-1:0]        pos_s2;
	logic [2:0][30:0]     m_s3, m_s4, m_s5;
	logic [2:0][61:0]     sq_s4;
	logic [63:0]          sum_s5;

	sqrt_st_t sq_s [NSQ];
	logic [31:0] len_d0;
	logic [31:0] len_c;
	div_st_t  div_d0;
	div_st_t  dv_s [NDIV];
	logic [31:0] dlen_s [NDIV];
	vec_t     vec_s;

	// side line: tag, input signs, zero-vector flag
	assign side_in = {tag_i, v_i[2][IN_W-1], v_i[1][IN_W-1], v_i[0][IN_W-1], v_i == '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s <= {side_s[LAT-2:0], side_in};
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			mag_c[l] = v_i[l][IN_W-1] ? (IN_W)'(-v_i[l]) : v_i[l];
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
		pos_c = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (mx_s1[b]) pos_c = PW'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			mx_s1  <= mx_c;
			mag_s2 <= mag_s1;
			pos_s2 <= pos_c;
			for (int l = 0; l < 3; l++) begin
				if (pos_s2 >= PW'(30)) begin
					m_s3[l] <= 31'(mag_s2[l] >> (pos_s2 - PW'(30)));
				end else begin
					m_s3[l] <= 31'(mag_s2[l] << (PW'(30) - pos_s2));
				end
				sq_s4[l] <= 62'(m_s3[l]) * 62'(m_s3[l]);
			end
			m_s4   <= m_s3;
			sum_s5 <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			m_s5   <= m_s4;
		end
	end

	genvar j;
	for (j = 0; j < NSQ; j++) begin : g_sqrt
		sqrt_st_t cur;
		if (j == 0) begin : g_first
			assign cur = '{n: sum_s5, r: 64'd0, m: m_s5};
		end else begin : g_next
			assign cur = sq_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[j] <= sqrt_step(sqrt_step(cur, 2 * j), 2 * j + 1);
			end
		end
	end

	assign len_c = sq_s[NSQ-1].r[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			len_d0 <= len_c;
			for (int l = 0; l < 3; l++) begin
				// numerator m * 2^30 + len / 2, top bits start the remainder
				{div_d0.rem[l][30:0], div_d0.lo[l]} <=
					(62'(sq_s[NSQ-1].m[l]) << 30) + 62'(len_c >> 1);
				div_d0.rem[l][31] <= 1'b0;
			end
		end
	end

	for (j = 0; j < NDIV; j++) begin : g_div
		div_st_t     cur;
		div_st_t     nxt;
		logic [31:0] len;
		if (j == 0) begin : g_first
			assign cur = div_d0;
			assign len = len_d0;
		end else begin : g_next
			assign cur = dv_s[j-1];
			assign len = dlen_s[j-1];
		end
		if (2 * j + 1 < DIV_STEPS) begin : g_two
			assign nxt = div_step(div_step(cur, len), len);
		end else begin : g_one
			assign nxt = div_step(cur, len);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j]   <= nxt;
				dlen_s[j] <= len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[LAT-2][0]) begin
				vec_s <= '0;
			end else begin
				vec_s.x <= side_s[LAT-2][1] ? -$signed({1'b0, dv_s[NDIV-1].lo[0]})
					: $signed({1'b0, dv_s[NDIV-1].lo[0]});
				vec_s.y <= side_s[LAT-2][2] ? -$signed({1'b0, dv_s[NDIV-1].lo[1]})
					: $signed({1'b0, dv_s[NDIV-1].lo[1]});
				vec_s.z <= side_s[LAT-2][3] ? -$signed({1'b0, dv_s[NDIV-1].lo[2]})
					: $signed({1'b0, dv_s[NDIV-1].lo[2]});
			end
		end
	end

	assign vld_o = vld_s[LAT-1];
	assign vec_o = vec_s;
	assign tag_o = side_s[LAT-1][SW-1:4];

	// scaled sum of squares is at least 2^60, so the root lands in [2^30, 2^32)
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4+NSQ] && !side_s[4+NSQ][0] |->
			sq_s[NSQ-1].r[63:32] == '0 && sq_s[NSQ-1].r[31:30] != 2'b00)
		else $error("norm: square root out of range");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5+NSQ+NDIV] && !side_s[5+NSQ+NDIV][0] |->
			dv_s[NDIV-1].lo[0] <= 31'h4000_0000 && dv_s[NDIV-1].lo[1] <= 31'h4000_0000
			&& dv_s[NDIV-1].lo[2] <= 31'h4000_0000)
		else $error("norm: quotient above one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("norm: valid line moved while stalled");

endmodule

`default_nettype wire

/* design/euler_camera_basis_view.sv */
// Euler-angle camera basis (front, right, up) and look-at view translation.
//
// Channels: pose (sink) carries yaw and pitch in binary angle units and the eye
// position in Q16.16; basis (source) carries the unit vectors in Q(FRAC_BITS) and
// the view translation -right.eye, -up.eye, front.eye in Q20.16. One item out per
// item in. The cfg write port sets the world up vector (index 0..2 = x, y, z);
// the user must make writes only while no item is in flight; the block does not enforce it.
//
// Pipeline from accept to basis.valid: the sine units, the front product, each of
// the three normalize pipelines (square root and dividers, two iterations per stage,
// one in the last divider stage), a register for each cross product, then the dot
// products and output rounding. Throughput: one item per cycle while not stalled.
//
// Reset clears every valid bit and loads world up (0, 1.0, 0). When the receiver
// stalls with a result held, the whole pipeline freezes and pose.ready drops in the
// same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module euler_camera_basis_view import cebv_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_wr_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
	cebv_pose_if.sink                  pose,
	cebv_basis_if.source               basis
);

	localparam int SH = 30 - FRAC_BITS;
	localparam logic [31:0] HALF_OUT = (32'd1 << SH) >> 1;
	localparam logic QCHK = (FRAC_BITS <= 14);

	function automatic logic signed [66:0] rshr30(input logic signed [66:0] v);
		logic [66:0] m;
		m = v[66] ? 67'(-v) : 67'(v);
		m = (m + (67'd1 << 29)) >> 30;
		return v[66] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [15:0] rnd_out(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		m = (m + HALF_OUT) >> SH;
		return v[31] ? 16'(-m) : m[15:0];
	endfunction

	logic en;
	logic signed [15:0] wu_x_q, wu_y_q, wu_z_q;

	logic [ANGLE_BITS-1:0] yaw_a, pitch_a, quarter;
	logic signed [31:0] cy, sy, cp, sp;

	logic [SINE_LAT-1:0] vld_s;
	vec_t                eye_s [SINE_LAT];

	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	logic [2:0][31:0] raw_s6;
	vec_t eye_s6;
	logic signed [66:0] pcc, psc;

	logic n1_vld, n2_vld, n3_vld;
	vec_t f1, eye1, r2, f2, eye2, u3, r3, f3, eye3;

	logic [2:0][48:0] c_s7;
	vec_t f_s7, eye_s7;
	logic [2:0][63:0] c_s8;
	vec_t f_s8, r_s8, eye_s8;

	logic signed [63:0] pr_s9 [3][3];
	vec_t f_s9, r_s9, u_s9;
	logic signed [65:0] sum_s10 [3];
	vec_t f_s10, r_s10, u_s10;

	logic [2:0][15:0] f_s11, r_s11, u_s11;
	logic [2:0][35:0] t_s11;
	logic signed [66:0] dx, dy, dz;

	assign en         = !vld_s11 || basis.ready;
	assign pose.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wu_x_q <= 16'sd0;
			wu_y_q <= 16'sd16384;
			wu_z_q <= 16'sd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_wr_idx))
				CFG_WU_X: wu_x_q <= cfg_wr_data;
				CFG_WU_Y: wu_y_q <= cfg_wr_data;
				CFG_WU_Z: wu_z_q <= cfg_wr_data;
				default:  ;
			endcase
		end
	end

	// angles wrap at ANGLE_BITS; cosine is sine a quarter turn on
	assign yaw_a   = ANGLE_BITS'(pose.yaw_angle);
	assign pitch_a = ANGLE_BITS'(pose.pitch_angle);
	assign quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	cebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_yaw (
		.clk(clk), .en(en), .angle(yaw_a + quarter), .sine(cy));
	cebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_yaw (
		.clk(clk), .en(en), .angle(yaw_a), .sine(sy));
	cebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_pitch (
		.clk(clk), .en(en), .angle(pitch_a + quarter), .sine(cp));
	cebv_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_pitch (
		.clk(clk), .en(en), .angle(pitch_a), .sine(sp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s   <= {vld_s[SINE_LAT-2:0], pose.valid};
			vld_s6  <= vld_s[SINE_LAT-1];
			vld_s7  <= n1_vld;
			vld_s8  <= n2_vld;
			vld_s9  <= n3_vld;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	assign pcc = 67'(cy) * 67'(cp);
	assign psc = 67'(sy) * 67'(cp);

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s[0] <= '{x: pose.eye_x, y: pose.eye_y, z: pose.eye_z};
			for (int k = 1; k < SINE_LAT; k++) begin
				eye_s[k] <= eye_s[k-1];
			end
			raw_s6[0] <= 32'(rshr30(pcc));
			raw_s6[1] <= sp;
			raw_s6[2] <= 32'(rshr30(psc));
			eye_s6    <= eye_s[SINE_LAT-1];
		end
	end

	cebv_norm #(.IN_W(32), .TAG_W(96)) u_norm_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s6), .v_i(raw_s6), .tag_i(eye_s6),
		.vld_o(n1_vld), .vec_o(f1), .tag_o(eye1));

	// right = front x world up
	always_ff @(posedge clk) begin
		if (en) begin
			c_s7[0] <= 49'(f1.y) * 49'(wu_z_q) - 49'(f1.z) * 49'(wu_y_q);
			c_s7[1] <= 49'(f1.z) * 49'(wu_x_q) - 49'(f1.x) * 49'(wu_z_q);
			c_s7[2] <= 49'(f1.x) * 49'(wu_y_q) - 49'(f1.y) * 49'(wu_x_q);
			f_s7    <= f1;
			eye_s7  <= eye1;
		end
	end

	cebv_norm #(.IN_W(49), .TAG_W(192)) u_norm_right (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s7), .v_i(c_s7), .tag_i({eye_s7, f_s7}),
		.vld_o(n2_vld), .vec_o(r2), .tag_o({eye2, f2}));

	// up = right x front
	always_ff @(posedge clk) begin
		if (en) begin
			c_s8[0] <= 64'(r2.y) * 64'(f2.z) - 64'(r2.z) * 64'(f2.y);
			c_s8[1] <= 64'(r2.z) * 64'(f2.x) - 64'(r2.x) * 64'(f2.z);
			c_s8[2] <= 64'(r2.x) * 64'(f2.y) - 64'(r2.y) * 64'(f2.x);
			f_s8    <= f2;
			r_s8    <= r2;
			eye_s8  <= eye2;
		end
	end

	cebv_norm #(.IN_W(64), .TAG_W(288)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s8), .v_i(c_s8), .tag_i({eye_s8, f_s8, r_s8}),
		.vld_o(n3_vld), .vec_o(u3), .tag_o({eye3, f3, r3}));

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s9[0][0] <= 64'(r3.x) * 64'(eye3.x);
			pr_s9[0][1] <= 64'(r3.y) * 64'(eye3.y);
			pr_s9[0][2] <= 64'(r3.z) * 64'(eye3.z);
			pr_s9[1][0] <= 64'(u3.x) * 64'(eye3.x);
			pr_s9[1][1] <= 64'(u3.y) * 64'(eye3.y);
			pr_s9[1][2] <= 64'(u3.z) * 64'(eye3.z);
			pr_s9[2][0] <= 64'(f3.x) * 64'(eye3.x);
			pr_s9[2][1] <= 64'(f3.y) * 64'(eye3.y);
			pr_s9[2][2] <= 64'(f3.z) * 64'(eye3.z);
			f_s9 <= f3;
			r_s9 <= r3;
			u_s9 <= u3;
			for (int k = 0; k < 3; k++) begin
				sum_s10[k] <= 66'(pr_s9[k][0]) + 66'(pr_s9[k][1]) + 66'(pr_s9[k][2]);
			end
			f_s10 <= f_s9;
			r_s10 <= r_s9;
			u_s10 <= u_s9;
		end
	end

	assign dx = rshr30(67'(sum_s10[0]));
	assign dy = rshr30(67'(sum_s10[1]));
	assign dz = rshr30(67'(sum_s10[2]));

	always_ff @(posedge clk) begin
		if (en) begin
			f_s11 <= {rnd_out(f_s10.z), rnd_out(f_s10.y), rnd_out(f_s10.x)};
			r_s11 <= {rnd_out(r_s10.z), rnd_out(r_s10.y), rnd_out(r_s10.x)};
			u_s11 <= {rnd_out(u_s10.z), rnd_out(u_s10.y), rnd_out(u_s10.x)};
			t_s11[0] <= 36'(-dx);
			t_s11[1] <= 36'(-dy);
			t_s11[2] <= dz[35:0];
		end
	end

	assign basis.valid   = vld_s11;
	assign basis.front_x = f_s11[0];
	assign basis.front_y = f_s11[1];
	assign basis.front_z = f_s11[2];
	assign basis.right_x = r_s11[0];
	assign basis.right_y = r_s11[1];
	assign basis.right_z = r_s11[2];
	assign basis.up_x    = u_s11[0];
	assign basis.up_y    = u_s11[1];
	assign basis.up_z    = u_s11[2];
	assign basis.view_tx = t_s11[0];
	assign basis.view_ty = t_s11[1];
	assign basis.view_tz = t_s11[2];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s) && $stable(vld_s6))
		else $error("top: pipeline moved while stalled");

	a_front_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		QCHK && vld_s11 |-> f_s11 != '0)
		else $error("top: front vector is zero");

	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		QCHK && vld_s11 |-> (r_s11 == '0) == (u_s11 == '0))
		else $error("top: right and up disagree on degeneracy");

	a_zero_tx: assert property (@(posedge clk) disable iff (!arst_n)
		QCHK && vld_s11 && r_s11 == '0 |-> t_s11[0] == '0 && t_s11[1] == '0)
		else $error("top: translation nonzero with zero basis");

endmodule

`default_nettype wire

/* sim/tb_euler_camera_basis_view.sv */
// Testbench for euler_camera_basis_view: random and directed poses under several world up
// settings, checked against a built-in fixed-point predictor. Needs cebv_pkg and cebv_if.
`timescale 1ns / 1ps

typedef struct {
	bit [35:0] fld[12];	// front, right, up (16 bits each), then view_tx/ty/tz
} basis_rec_t;

class basis_scoreboard;
	basis_rec_t expq[$];
	int unsigned mismatches;
	int unsigned checked;

	function new();
		mismatches = 0;
		checked = 0;
	endfunction

	function longint unsigned quarter_sine(longint unsigned r);
		longint unsigned z, z2, p, q;
		z = r << 16;
		z2 = (z * z) >> 30;
		p = 64'd688904866 - ((64'd76016977 * z2) >> 30);
		q = 64'd1686629713 - ((p * z2) >> 30);
		return (q * z) >> 30;
	endfunction

	function longint sine_q30(bit [15:0] a);
		longint s;
		if (a[14])
			s = longint'(quarter_sine(64'd16384 - a[13:0]));
		else
			s = longint'(quarter_sine(a[13:0]));
		return a[15] ? -s : s;
	endfunction

	// Round half away from zero while dropping sh bits.
	function longint round_shift(longint v, int sh);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : v;
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function void to_unit(input longint v[3], output longint o[3]);
		longint unsigned m[3], mx, sum, len, q;
		int d, e;
		d = 0;
		e = 0;
		for (int i = 0; i < 3; i++)
			m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		if (mx == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 31)) begin mx >>= 1; d++; end
		while (mx < (64'd1 << 30)) begin mx <<= 1; e++; end
		for (int i = 0; i < 3; i++)
			m[i] = (m[i] >> d) << e;
		sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + (len >> 1)) / len;
			o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
	endfunction

	function longint eye_dot(longint v[3], longint eye[3]);
		return round_shift(v[0] * eye[0] + v[1] * eye[1] + v[2] * eye[2], 30);
	endfunction

	// Accepted pose: work out the basis and view translation it must produce.
	function void note_pose(bit [15:0] yaw, bit [15:0] pitch, bit [31:0] ex, bit [31:0] ey,
			bit [31:0] ez, bit [15:0] wux, bit [15:0] wuy, bit [15:0] wuz);
		longint cy, sy, cp, sp, t0, t1, t2;
		longint eye[3], wu[3], raw[3], f[3], c[3], r[3], u[3];
		basis_rec_t rec;
		cy = sine_q30(yaw + 16'd16384);
		sy = sine_q30(yaw);
		cp = sine_q30(pitch + 16'd16384);
		sp = sine_q30(pitch);
		eye = '{longint'($signed(ex)), longint'($signed(ey)), longint'($signed(ez))};
		wu = '{longint'($signed(wux)), longint'($signed(wuy)), longint'($signed(wuz))};
		raw = '{round_shift(cy * cp, 30), sp, round_shift(sy * cp, 30)};
		to_unit(raw, f);
		c = '{f[1] * wu[2] - f[2] * wu[1], f[2] * wu[0] - f[0] * wu[2],
			f[0] * wu[1] - f[1] * wu[0]};
		to_unit(c, r);
		c = '{r[1] * f[2] - r[2] * f[1], r[2] * f[0] - r[0] * f[2],
			r[0] * f[1] - r[1] * f[0]};
		to_unit(c, u);
		t0 = -eye_dot(r, eye);
		t1 = -eye_dot(u, eye);
		t2 = eye_dot(f, eye);
		for (int i = 0; i < 3; i++) begin
			rec.fld[i] = {20'd0, 16'(round_shift(f[i], 16))};
			rec.fld[3 + i] = {20'd0, 16'(round_shift(r[i], 16))};
			rec.fld[6 + i] = {20'd0, 16'(round_shift(u[i], 16))};
		end
		rec.fld[9] = 36'(t0);
		rec.fld[10] = 36'(t1);
		rec.fld[11] = 36'(t2);
		expq.push_back(rec);
	endfunction

	function void check_basis(basis_rec_t got);
		string nm[12] = '{"front_x", "front_y", "front_z", "right_x", "right_y", "right_z",
			"up_x", "up_y", "up_z", "view_tx", "view_ty", "view_tz"};
		basis_rec_t want;
		if (expq.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected basis item at %0t", $realtime);
			return;
		end
		want = expq.pop_front();
		for (int i = 0; i < 12; i++)
			if (want.fld[i] !== got.fld[i]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("item %0d %s: expected %h actual %h", checked, nm[i],
						want.fld[i], got.fld[i]);
			end
		checked++;
	endfunction
endclass

module tb_euler_camera_basis_view;
	import cebv_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_wr_idx;
	logic [CFG_DATA_W-1:0] cfg_wr_data;
	logic [15:0] wu_x, wu_y, wu_z;	// mirror of the world up registers
	int tx_idle, rx_idle, hold_left;

	cebv_pose_if pose_ch();
	cebv_basis_if basis_ch();
	basis_scoreboard sb;

	euler_camera_basis_view u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_idx(cfg_wr_idx),
		.cfg_wr_data(cfg_wr_data),
		.pose(pose_ch),
		.basis(basis_ch)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when the main sequence sets hold_left.
	initial begin
		basis_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				basis_ch.ready <= 1'b0;
			end else begin
				basis_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		basis_rec_t got;
		if (arst_n && basis_ch.valid && basis_ch.ready) begin
			got.fld[0] = {20'd0, basis_ch.front_x};
			got.fld[1] = {20'd0, basis_ch.front_y};
			got.fld[2] = {20'd0, basis_ch.front_z};
			got.fld[3] = {20'd0, basis_ch.right_x};
			got.fld[4] = {20'd0, basis_ch.right_y};
			got.fld[5] = {20'd0, basis_ch.right_z};
			got.fld[6] = {20'd0, basis_ch.up_x};
			got.fld[7] = {20'd0, basis_ch.up_y};
			got.fld[8] = {20'd0, basis_ch.up_z};
			got.fld[9] = basis_ch.view_tx;
			got.fld[10] = basis_ch.view_ty;
			got.fld[11] = basis_ch.view_tz;
			sb.check_basis(got);
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_wr_idx <= idx;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_WU_X: wu_x = val;
			CFG_WU_Y: wu_y = val;
			default:  wu_z = val;
		endcase
		@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pose(bit [15:0] yaw, bit [15:0] pitch, bit [31:0] ex, bit [31:0] ey,
			bit [31:0] ez);
		while ($urandom_range(0, 99) < tx_idle) begin
			pose_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pose_ch.valid <= 1'b1;
		pose_ch.yaw_angle <= yaw;
		pose_ch.pitch_angle <= pitch;
		pose_ch.eye_x <= ex;
		pose_ch.eye_y <= ey;
		pose_ch.eye_z <= ez;
		do @(posedge clk); while (!pose_ch.ready);
		sb.note_pose(yaw, pitch, ex, ey, ez, wu_x, wu_y, wu_z);
		@(negedge clk);
	endtask

	function automatic bit [31:0] rand_eye();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random();
		bit [15:0] yaw, pitch;
		yaw = $urandom;
		pitch = $urandom;
		case ($urandom_range(0, 9))
			0: pitch = $urandom_range(0, 1) ? 16'd16384 : 16'd49152;	// at a pole
			1: pitch = ($urandom_range(0, 1) ? 16'd16384 : 16'd49152) + $urandom_range(0, 8) - 4;
			2: begin
				yaw = 16'($urandom_range(0, 3)) << 14;
				pitch = 16'($urandom_range(0, 3)) << 14;
			end
			default: ;
		endcase
		send_pose(yaw, pitch, rand_eye(), rand_eye(), rand_eye());
	endtask

	task automatic drain();
		pose_ch.valid <= 1'b0;
		while (sb.expq.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] up_sets[6][3];
		bit [15:0] dyaw[8];
		bit [15:0] dpitch[8];
		up_sets = '{'{16'd16384, 16'd0, 16'd0}, '{-16'sd16384, -16'sd16384, -16'sd16384},
			'{16'd16384, 16'd16384, 16'd16384}, '{16'd0, 16'd0, 16'd0},
			'{16'h7fff, 16'h8000, 16'h0001}, '{16'd0, -16'sd16384, 16'd0}};
		dyaw = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd8192, 16'd1, 16'd12345};
		dpitch = '{16'd0, 16'd16384, 16'd49152, 16'd32768, 16'd65535, 16'd1, 16'd16383,
			16'd49153};
		sb = new();
		tx_idle = 12;
		rx_idle = 52;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_idx = CFG_WU_X;
		cfg_wr_data = '0;
		wu_x = 16'd0;
		wu_y = 16'd16384;
		wu_z = 16'd0;
		pose_ch.valid = 1'b0;
		pose_ch.yaw_angle = '0;
		pose_ch.pitch_angle = '0;
		pose_ch.eye_x = '0;
		pose_ch.eye_y = '0;
		pose_ch.eye_z = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: quadrant angles, poles, wrap edges and extreme eyes.
		for (int i = 0; i < 8; i++)
			send_pose(dyaw[i], dpitch[i], 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
		for (int i = 0; i < 8; i++)
			send_pose(dyaw[7 - i], dpitch[i], 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		send_pose(16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
		send_pose(16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_WU_X, up_sets[ph][0]);
			write_reg(CFG_WU_Y, up_sets[ph][1]);
			write_reg(CFG_WU_Z, up_sets[ph][2]);
			tx_idle = (ph < 2) ? 12 : (ph < 4) ? 52 : 0;
			rx_idle = (ph < 2) ? 52 : (ph < 4) ? 12 : 0;
			if (ph == 4)
				hold_left = 400;	// long stall so the pipeline backs up into the input
			// parallel-to-front case for the x up set
			if (ph == 0)
				send_pose(16'd0, 16'd0, rand_eye(), rand_eye(), rand_eye());
			for (int n = 0; n < 250; n++)
				send_random();
			drain();
		end

		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
